// File: hdl/grs_pkg.sv
package grs_pkg;

	localparam int VAL_W = 32;
	localparam int GS_W  = 5;

	localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd;
		logic adv;
	} grs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;
		logic run_end;
	} grs_sts_t;

endpackage

// File: hdl/group_reverse_stream_unit.sv
// Group reverse stream: values arrive one beat at a time and are held in a
// MAX_GROUP-entry buffer until group_size of them are collected, then the
// group leaves reversed; a sequence that ends (last_item) on a partial group
// sends the remainder in arrival order. group_size is clamped to 1..MAX_GROUP
// and should be written between sequences. A beat that starts a run
// of results blocks the input until the run is drained: each result is
// read from the buffer into the read register and then offered as an
// output beat from that register, which holds while out_ready is low.
module group_reverse_stream_unit import grs_pkg::*; #(
	parameter int MAX_GROUP = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [GS_W-1:0]         cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] value_res,
	output logic                    last_of_run,
	output logic                    end_of_sequence
);

	grs_cmd_t cmd;
	grs_sts_t sts;
	logic     cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	grs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	grs_dp #(
		.MAX_GROUP (MAX_GROUP)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.value           (value),
		.last_item       (last_item),
		.cmd             (cmd),
		.sts             (sts),
		.value_res       (value_res),
		.last_of_run     (last_of_run),
		.end_of_sequence (end_of_sequence)
	);

endmodule

// File: hdl/grs_ctrl.sv
module grs_ctrl import grs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  grs_sts_t sts,
	output grs_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign cmd.accept = in_valid && in_ready;
	assign cmd.rd     = (state_q == S_RD);
	assign cmd.adv    = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept && sts.emit) state_d = S_RD;
			end
			S_RD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				// drop back to idle after the final beat of the run
				if (out_ready) state_d = sts.run_end ? S_IDLE : S_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> out_valid)
		else $error("buffer read not followed by a result beat");

	a_run_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.adv && sts.run_end) |=> in_ready)
		else $error("controller not idle after end of run");
`endif

endmodule

// File: hdl/grs_dp.sv
module grs_dp import grs_pkg::*; #(
	parameter int MAX_GROUP = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [GS_W-1:0]         cfg_data,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_item,
	input  grs_cmd_t                cmd,
	output grs_sts_t                sts,
	output logic signed [VAL_W-1:0] value_res,
	output logic                    last_of_run,
	output logic                    end_of_sequence
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int KW = (CW > GS_W) ? CW : GS_W;

	logic signed [VAL_W-1:0] mem [MAX_GROUP];

	logic [GS_W-1:0]         group_size_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           rem_q;
	logic [AW-1:0]           pos_q;
	logic                    rev_q;
	logic                    seq_end_q;
	logic                    run_end_q;
	logic signed [VAL_W-1:0] rd_data_q;

	logic                    store;
	logic [CW-1:0]           fill_n;
	logic [KW-1:0]           gs_ext;
	logic [KW-1:0]           k_eff;
	logic                    full_grp;

	assign store  = (fill_q < CW'(MAX_GROUP));
	assign fill_n = store ? (fill_q + CW'(1)) : fill_q;

	// clamp group size to 1..MAX_GROUP
	always_comb begin
		gs_ext = KW'(group_size_q);
		if (gs_ext == '0) begin
			k_eff = KW'(1);
		end else if (gs_ext > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end

	assign full_grp    = (KW'(fill_n) >= k_eff);
	assign sts.emit    = full_grp || last_item;
	assign sts.run_end = run_end_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && store) mem[fill_q[AW-1:0]] <= value;
		if (cmd.rd) rd_data_q <= mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GS_RESET;
			fill_q       <= '0;
			rem_q        <= '0;
			pos_q        <= '0;
			rev_q        <= 1'b0;
			seq_end_q    <= 1'b0;
			run_end_q    <= 1'b0;
		end else begin
			if (cfg_we) group_size_q <= cfg_data;
			if (cmd.accept) begin
				if (sts.emit) begin
					// start a run: reversed for a full group, in order for a tail
					fill_q    <= '0;
					rem_q     <= fill_n;
					rev_q     <= full_grp;
					seq_end_q <= last_item;
					pos_q     <= full_grp ? AW'(fill_n - CW'(1)) : '0;
				end else begin
					fill_q <= fill_n;
				end
			end
			if (cmd.rd) run_end_q <= (rem_q == CW'(1));
			if (cmd.adv) begin
				rem_q <= rem_q - CW'(1);
				pos_q <= rev_q ? (pos_q - AW'(1)) : (pos_q + AW'(1));
			end
		end
	end

	assign value_res       = rd_data_q;
	assign last_of_run     = run_end_q;
	assign end_of_sequence = run_end_q && seq_end_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(MAX_GROUP))
		else $error("fill count reached buffer depth");

	a_rd_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (rem_q != '0))
		else $error("buffer read with no result left in the run");
`endif

endmodule

// File: tb/group_reverse_monitor.sv
module group_reverse_monitor import grs_pkg::*; #(
	parameter int MAX_GROUP = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [GS_W-1:0]         cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_item,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [VAL_W-1:0] value_res,
	input  logic                    last_of_run,
	input  logic                    end_of_sequence,
	output int                      pending,
	output int                      errors
);

	typedef struct {
		logic signed [VAL_W-1:0] val;
		logic                    run_end;
		logic                    seq_end;
	} reorder_beat_t;

	reorder_beat_t           due_beats[$];
	logic signed [VAL_W-1:0] held_vals[MAX_GROUP];
	int                      held_cnt = 0;
	logic [GS_W-1:0]         group_size = GS_RESET;
	int                      err_cnt = 0;

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic predict_reorder(input logic signed [VAL_W-1:0] v, input logic last);
		int            k;
		int            n;
		reorder_beat_t b;
		k = (group_size == 0) ? 1 : ((group_size > MAX_GROUP) ? MAX_GROUP : int'(group_size));
		if (held_cnt < MAX_GROUP) begin
			held_vals[held_cnt] = v;
			held_cnt++;
		end
		n = held_cnt;
		if (n >= k || last) begin
			// full group leaves reversed, a short tail at sequence end in arrival order
			for (int i = 0; i < n; i++) begin
				b.val     = (n >= k) ? held_vals[n-1-i] : held_vals[i];
				b.run_end = (i == n - 1);
				b.seq_end = (i == n - 1) && last;
				due_beats.push_back(b);
			end
			held_cnt = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reorder_beat_t want;
		if (!arst_n) begin
			group_size = GS_RESET;
			held_cnt   = 0;
			err_cnt    = 0;
			due_beats.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			// compare before predicting: no result may leave on its own input beat
			if (out_valid && out_ready) begin
				if (due_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat value_res=%0d", value_res));
				end else begin
					want = due_beats.pop_front();
					if (value_res !== want.val)
						report_mismatch($sformatf("value_res got %0d want %0d",
							value_res, want.val));
					if (last_of_run !== want.run_end)
						report_mismatch($sformatf("last_of_run got %b want %b",
							last_of_run, want.run_end));
					if (end_of_sequence !== want.seq_end)
						report_mismatch($sformatf("end_of_sequence got %b want %b",
							end_of_sequence, want.seq_end));
				end
			end
			if (in_valid && in_ready)
				predict_reorder(value, last_item);
			if (cfg_valid && cfg_ready)
				group_size = cfg_data;
			pending <= due_beats.size();
			errors  <= err_cnt;
		end
	end

endmodule

// File: tb/group_reverse_stream_unit_tb.sv
module group_reverse_stream_unit_tb;
	import grs_pkg::*;

	localparam int MAX_GROUP   = 16;
	localparam int HALF_PERIOD = 6;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [GS_W-1:0]         cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [VAL_W-1:0] value;
	logic                    last_item;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] value_res;
	logic                    last_of_run;
	logic                    end_of_sequence;
	int                      pending;
	int                      errors;
	logic                    calm;
	int                      stall_left = 0;

	group_reverse_stream_unit #(.MAX_GROUP(MAX_GROUP)) dut (.*);

	group_reverse_monitor #(.MAX_GROUP(MAX_GROUP)) mon (.*);

	always #HALF_PERIOD clk = ~clk;

	// output side: random stall bursts
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(input logic signed [VAL_W-1:0] v, input logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		value     <= v;
		last_item <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold input until every predicted beat is out, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [GS_W-1:0] g);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [GS_W-1:0] g, input int items);
		int  left;
		int  seq_len;
		logic cut;
		write_group_size(g);
		left = items;
		while (left > 0) begin
			seq_len = $urandom_range(1, 2 * MAX_GROUP + 4);
			// a cut sequence leaves a partial group held across the next size change
			cut = (seq_len > left);
			if (cut)
				seq_len = left;
			for (int i = 0; i < seq_len; i++) begin
				if (!calm && $urandom_range(0, 39) == 0)
					wait_drained();
				push_item(pick_value(), (i == seq_len - 1) && !cut);
			end
			left -= seq_len;
		end
	endtask

	initial begin
		#(HALF_PERIOD * 2 * 200000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int guard;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		value      = '0;
		last_item  = 1'b0;
		calm       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// size one after reset: straight pass-through
		push_item(VAL_MAX, 1'b0);
		push_item(VAL_MIN, 1'b1);

		write_group_size(5'd3);
		push_item(-1, 1'b0);
		push_item(0, 1'b0);
		push_item(32'sh55555555, 1'b0);
		push_item(32'shAAAAAAAA, 1'b0);
		push_item(7, 1'b1);
		// group closes exactly on the sequence end
		push_item(1, 1'b0);
		push_item(2, 1'b0);
		push_item(3, 1'b1);

		// shrink the size under two held values
		push_item(10, 1'b0);
		push_item(11, 1'b0);
		write_group_size(5'd2);
		push_item(12, 1'b0);
		push_item(13, 1'b1);

		// zero acts as one
		write_group_size(5'd0);
		push_item(4, 1'b0);
		push_item(5, 1'b1);

		// oversize clamps to the buffer depth
		write_group_size(5'd31);
		push_item(-7, 1'b0);
		push_item(VAL_MIN, 1'b0);
		push_item(VAL_MAX, 1'b1);

		run_phase(5'd2, 35);
		run_phase(5'd16, 45);
		run_phase(5'd1, 25);
		run_phase(5'd5, 35);
		run_phase(5'd17, 40);
		run_phase(5'd4, 35);
		run_phase(5'd0, 25);
		run_phase(5'd8, 35);
		run_phase(5'd15, 40);
		run_phase(GS_W'($urandom_range(0, 31)), 35);
		run_phase(5'd3, 35);
		calm <= 1'b1;
		run_phase(5'd7, 60);

		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending != 0 && guard < 4000);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
